[rtl/windowed_softmax_attention_top_assert.svh]
// Assertion macros used by the checker of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef WINDOWED_SOFTMAX_ATTENTION_TOP_ASSERT_SVH
`define WINDOWED_SOFTMAX_ATTENTION_TOP_ASSERT_SVH

// Check a condition in the cycle after a trigger, ignored while reset is high.
`define WSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check a condition in the cycle after a trigger, reset included.
`define WSA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wsa_pkg.sv]
// ----------------------------------------------------------------------------
// wsa_pkg
// Types and fixed constants of the windowed softmax attention block.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] TOKEN_COUNT_RESET = 8'd128;

  // Scaled scores stay within +/-2^23 for any head dimension from 16 to 256.
  localparam int SCORE_W = 26;

  // log2(e) in Q.16, and right shift of the exponent step.
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam int          LOG2E_SHIFT = 23;

  localparam int PROB_W = 16;
  localparam int EXP_W  = 17;

  // round(65536 * 2^(-j/16))
  localparam logic [EXP_W-1:0] EXP2_FRAC [16] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535, 17'd48393,
    17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219
  };

  typedef struct packed {
    logic              op;
    logic [6:0]        token;
    logic [6:0]        dim;
    logic signed [15:0] query_value;
    logic signed [15:0] key_value;
    logic signed [15:0] value_value;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [6:0]         out_token;
    logic [6:0]         out_dim;
  } result_t;

endpackage

[rtl/wsa_ram.sv]
// ----------------------------------------------------------------------------
// wsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/wsa_div.sv]
// ----------------------------------------------------------------------------
// wsa_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the upper part of the numerator is below the divisor.
// ----------------------------------------------------------------------------
module wsa_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   nsh;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem, nsh[Q_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= DEN_W'(num >> Q_W);
        nsh    <= num[Q_W-1:0];
        den_r  <= den;
        cnt    <= CNT_W'(Q_W);
        active <= 1'b1;
      end else if (active) begin
        // shift in one numerator bit, subtract when it fits
        rem <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        quo <= {quo[Q_W-2:0], qbit};
        nsh <= {nsh[Q_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/windowed_softmax_attention_top.sv]
// ----------------------------------------------------------------------------
// windowed_softmax_attention_top
// One attention head over one window of tokens, with cached softmax rows.
// ----------------------------------------------------------------------------
// A load beat (op = 0) writes one query, key and value element and leaves the
// block idle; it also invalidates the cached probability row. A read beat
// (op = 1) returns output element (token, dim). When the requested row is not
// cached, the block first walks every valid key: dot products through the query
// and key RAMs (one multiply-accumulate a cycle), then scores turned into
// exponents, then the probabilities from the divider. Every read then walks
// the n tokens, one value and one probability RAM read per token, where n is
// the effective token count. Reads outside the token count or the head return
// zero. The result sits in an output register, so the next beat is taken while
// it waits.
// ----------------------------------------------------------------------------
module windowed_softmax_attention_top
  import wsa_pkg::*;
#(
  parameter int MAX_TOKENS = 128,
  parameter int HEAD_DIM   = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result,
  input  logic    config_valid,
  output logic    config_ready,
  input  logic [7:0] config_data
);

  // Rounded integer square root, used at elaboration for the score scale.
  function automatic longint unsigned isqrt_round(input longint unsigned x);
    longint unsigned rem_v;
    longint unsigned res_v;
    longint unsigned bt;
    rem_v = x;
    res_v = 0;
    bt    = 64'd1 << 62;
    while (bt > rem_v) bt = bt >> 2;
    while (bt != 0) begin
      if (rem_v >= res_v + bt) begin
        rem_v = rem_v - (res_v + bt);
        res_v = (res_v >> 1) + bt;
      end else begin
        res_v = res_v >> 1;
      end
      bt = bt >> 2;
    end
    if (x - res_v * res_v > res_v) res_v = res_v + 1;
    return res_v;
  endfunction

  localparam int DEPTH = MAX_TOKENS * HEAD_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(MAX_TOKENS);
  localparam int CW    = $clog2(MAX_TOKENS + 1);
  localparam int DW    = $clog2(HEAD_DIM);
  localparam longint unsigned SCALE_ARG = (64'd1 << 32) / HEAD_DIM;
  localparam int SCALE = int'(isqrt_round(SCALE_ARG));
  localparam int SC_W  = $clog2(SCALE + 1);
  localparam int ACC_W = 35 + $clog2(MAX_TOKENS > HEAD_DIM ? MAX_TOKENS : HEAD_DIM);
  localparam int HI_W  = ACC_W - 20;
  localparam int XW    = ACC_W + SC_W + 2;
  localparam int EP_W  = SCORE_W + 17;
  localparam int IP_W  = EP_W - LOG2E_SHIFT - 3;
  localparam int SUM_W = EXP_W + TW;
  localparam int NUM_W = SUM_W + 16;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DOT       = 14'b00000000000010,
    S_DRAIN     = 14'b00000000000100,
    S_SCALE     = 14'b00000000001000,
    S_SCORE     = 14'b00000000010000,
    S_EXP_RD    = 14'b00000000100000,
    S_EXP_MUL   = 14'b00000001000000,
    S_EXP_WR    = 14'b00000010000000,
    S_DIV_RD    = 14'b00000100000000,
    S_DIV_GO    = 14'b00001000000000,
    S_DIV_WAIT  = 14'b00010000000000,
    S_MAC       = 14'b00100000000000,
    S_MAC_DRAIN = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [7:0]  token_count;
  logic        cache_valid;
  logic [6:0]  cached_row;
  logic [6:0]  rd_token;
  logic [6:0]  rd_dim;
  logic [CW-1:0] b;
  logic [DW-1:0] d;
  logic [AW-1:0] qbase;
  logic [AW-1:0] kaddr;
  logic [AW-1:0] vaddr;
  logic        p1_valid;
  logic        p2_valid;
  logic        mac_mode;
  logic signed [33:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [HI_W+SC_W:0] prod_hi;
  logic signed [21+SC_W:0]   prod_lo;
  logic signed [SCORE_W-1:0] row_max;
  logic [EP_W-1:0]  exp_prod;
  logic [SUM_W-1:0] sum;
  logic signed [15:0] res_value;

  // datapath wires
  logic          accept;
  logic          load_wr;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] q_rd_addr;
  logic [AW-1:0] k_rd_addr;
  logic signed [15:0] q_rd;
  logic signed [15:0] k_rd;
  logic signed [15:0] v_rd;
  logic [PROB_W-1:0]  prob_rd;
  logic [SCORE_W-1:0] row_rd;
  logic [SCORE_W-1:0] row_wdata;
  logic          row_we;
  logic          prob_we;
  logic [CW-1:0] n_eff;
  logic          last_b;
  logic signed [16:0] ma;
  logic signed [16:0] mb;
  logic signed [XW-1:0] sx;
  logic [XW-1:0] sx_mag;
  logic [XW-1:0] sx_rnd;
  logic signed [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] diff;
  logic [EP_W:0]  t_sum;
  logic [EP_W-LOG2E_SHIFT:0] t16;
  logic [IP_W-1:0] ip;
  logic [EXP_W-1:0] e_val;
  logic          div_start;
  logic          div_done;
  logic [NUM_W-1:0] div_num;
  logic [PROB_W-1:0] div_q;
  logic [ACC_W-1:0] acc_mag;
  logic [ACC_W-1:0] acc_rnd;
  logic signed [15:0] out_sat;
  logic          rd_in_range;
  logic          cache_hit;

  // Clamp the token count: zero acts as one, anything above the window as full.
  always_comb begin
    if (token_count == 8'd0) begin
      n_eff = CW'(1);
    end else if (32'(token_count) > MAX_TOKENS) begin
      n_eff = CW'(MAX_TOKENS);
    end else begin
      n_eff = CW'(token_count);
    end
  end

  assign last_b       = (b == n_eff - CW'(1));
  assign accept       = item_valid && (state == S_IDLE);
  assign item_stall   = (state != S_IDLE);
  assign config_ready = (state == S_IDLE);

  // Loads write all three stores at the accept edge; out-of-range loads drop.
  assign load_addr = AW'(32'(item.token) * HEAD_DIM + 32'(item.dim));
  assign load_wr   = accept && (item.op == OP_LOAD) &&
                     (32'(item.token) < MAX_TOKENS) && (32'(item.dim) < HEAD_DIM);

  assign rd_in_range = (32'(item.token) < 32'(n_eff)) && (32'(item.dim) < HEAD_DIM);
  assign cache_hit   = cache_valid && (cached_row == item.token);

  assign q_rd_addr = qbase + AW'(d);
  assign k_rd_addr = kaddr + AW'(d);

  wsa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_query_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (load_addr),
    .wr_data (item.query_value),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd)
  );

  wsa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (load_addr),
    .wr_data (item.key_value),
    .rd_addr (k_rd_addr),
    .rd_data (k_rd)
  );

  wsa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (load_addr),
    .wr_data (item.value_value),
    .rd_addr (vaddr),
    .rd_data (v_rd)
  );

  // Scores first, then exponents written back over them in place.
  assign row_we    = (state == S_SCORE) || (state == S_EXP_WR);
  assign row_wdata = (state == S_SCORE) ? score : SCORE_W'(e_val);

  wsa_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_TOKENS)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (b[TW-1:0]),
    .wr_data (row_wdata),
    .rd_addr (b[TW-1:0]),
    .rd_data (row_rd)
  );

  assign prob_we = (state == S_DIV_WAIT) && div_done;

  wsa_ram #(.WIDTH(PROB_W), .DEPTH(MAX_TOKENS)) u_prob_ram (
    .clk     (clk),
    .wr_en   (prob_we),
    .wr_addr (b[TW-1:0]),
    .wr_data (div_q),
    .rd_addr (b[TW-1:0]),
    .rd_data (prob_rd)
  );

  // Shared multiplier: q*k while scoring, prob*value while summing.
  assign ma = mac_mode ? $signed({1'b0, prob_rd}) : $signed({q_rd[15], q_rd});
  assign mb = mac_mode ? $signed({v_rd[15], v_rd}) : $signed({k_rd[15], k_rd});

  // Score: rounded (dot * scale) / 2^27, half away from zero.
  always_comb begin
    sx     = (XW'(prod_hi) <<< 20) + XW'(prod_lo);
    sx_mag = sx[XW-1] ? XW'(-sx) : XW'(sx);
    sx_rnd = (sx_mag + (XW'(1) << 26)) >> 27;
    score  = sx[XW-1] ? -$signed(SCORE_W'(sx_rnd)) : $signed(SCORE_W'(sx_rnd));
  end

  // Exponent: 2^-(t/16) from the fraction table and a shift.
  always_comb begin
    diff  = SCORE_W'(row_max - $signed(row_rd));
    t_sum = {1'b0, exp_prod} + (EP_W+1)'(1 << (LOG2E_SHIFT - 1));
    t16   = t_sum[EP_W:LOG2E_SHIFT];
    ip    = t16[EP_W-LOG2E_SHIFT:4];
    if (32'(ip) >= 17) begin
      e_val = '0;
    end else begin
      e_val = EXP2_FRAC[t16[3:0]] >> ip[4:0];
    end
  end

  assign div_start = (state == S_DIV_GO);
  assign div_num   = (NUM_W'(row_rd[EXP_W-1:0]) << 15) + NUM_W'(sum >> 1);

  wsa_div #(.NUM_W(NUM_W), .DEN_W(SUM_W), .Q_W(PROB_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .done  (div_done),
    .quo   (div_q)
  );

  // Output: rounded acc / 2^15, saturated to 16 bits.
  always_comb begin
    acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    acc_rnd = (acc_mag + (ACC_W'(1) << 14)) >> 15;
    if (acc[ACC_W-1]) begin
      out_sat = (acc_rnd > ACC_W'(32768)) ? 16'sh8000 : -$signed(acc_rnd[15:0]);
    end else begin
      out_sat = (acc_rnd > ACC_W'(32767)) ? 16'sh7fff : $signed(acc_rnd[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      token_count  <= TOKEN_COUNT_RESET;
      cache_valid  <= 1'b0;
      cached_row   <= '0;
      result_valid <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
    end else begin
      // multiply-accumulate pipeline: RAM data, product, sum
      p1_valid <= (state == S_DOT) || (state == S_MAC);
      p2_valid <= p1_valid;
      if (p1_valid) prod <= ma * mb;
      if (p2_valid) acc <= acc + ACC_W'(prod);

      // drop the result once the far side takes it
      if (result_valid && !result_stall) result_valid <= 1'b0;

      if (config_valid && config_ready) begin
        token_count <= config_data;
        cache_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_token <= item.token;
            rd_dim   <= item.dim;
            if (item.op == OP_LOAD) begin
              cache_valid <= 1'b0;
            end else if (!rd_in_range) begin
              res_value <= '0;
              state     <= S_DONE;
            end else if (cache_hit) begin
              b        <= '0;
              vaddr    <= AW'(item.dim);
              acc      <= '0;
              mac_mode <= 1'b1;
              state    <= S_MAC;
            end else begin
              b        <= '0;
              d        <= '0;
              kaddr    <= '0;
              qbase    <= AW'(32'(item.token) * HEAD_DIM);
              acc      <= '0;
              mac_mode <= 1'b0;
              state    <= S_DOT;
            end
          end
        end
        S_DOT: begin
          if (d == DW'(HEAD_DIM - 1)) begin
            state <= S_DRAIN;
          end else begin
            d <= d + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!p1_valid && !p2_valid) state <= S_SCALE;
        end
        S_SCALE: begin
          // split the dot product so each multiply stays narrow
          prod_hi <= $signed(acc[ACC_W-1:20]) * $signed({1'b0, SC_W'(SCALE)});
          prod_lo <= $signed({1'b0, acc[19:0]}) * $signed({1'b0, SC_W'(SCALE)});
          state   <= S_SCORE;
        end
        S_SCORE: begin
          if (b == '0 || score > row_max) row_max <= score;
          if (last_b) begin
            b     <= '0;
            sum   <= '0;
            state <= S_EXP_RD;
          end else begin
            b     <= b + 1'b1;
            d     <= '0;
            kaddr <= kaddr + AW'(HEAD_DIM);
            acc   <= '0;
            state <= S_DOT;
          end
        end
        S_EXP_RD: begin
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          exp_prod <= EP_W'(diff) * EP_W'(LOG2E_Q16);
          state    <= S_EXP_WR;
        end
        S_EXP_WR: begin
          sum <= sum + SUM_W'(e_val);
          if (last_b) begin
            b     <= '0;
            state <= S_DIV_RD;
          end else begin
            b     <= b + 1'b1;
            state <= S_EXP_RD;
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (last_b) begin
              cache_valid <= 1'b1;
              cached_row  <= rd_token;
              b           <= '0;
              vaddr       <= AW'(rd_dim);
              acc         <= '0;
              mac_mode    <= 1'b1;
              state       <= S_MAC;
            end else begin
              b     <= b + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        S_MAC: begin
          if (last_b) begin
            state <= S_MAC_DRAIN;
          end else begin
            b     <= b + 1'b1;
            vaddr <= vaddr + AW'(HEAD_DIM);
          end
        end
        S_MAC_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            res_value <= out_sat;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!result_valid || !result_stall) begin
            result.out_value <= res_value;
            result.out_token <= rd_token;
            result.out_dim   <= rd_dim;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/wsa_checker.sv]
// ----------------------------------------------------------------------------
// wsa_checker
// Port-level checks of the windowed softmax attention block.
// ----------------------------------------------------------------------------
`include "windowed_softmax_attention_top_assert.svh"

module wsa_checker
  import wsa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input item_t      item,
  input logic       result_valid,
  input logic       result_stall,
  input result_t    result,
  input logic       config_valid,
  input logic       config_ready
);

  `WSA_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !result_valid && !item_stall, "not idle after reset")
  `WSA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")
  `WSA_ASSERT_NEXT(a_read_busy, item_valid && !item_stall && item.op == OP_READ, item_stall, "read beat did not occupy the block")
  `WSA_ASSERT_NEXT(a_load_single, item_valid && !item_stall && item.op == OP_LOAD, !item_stall, "load beat took more than one cycle")
  `WSA_ASSERT_NEXT(a_cfg_idle, config_valid && config_ready && !item_valid, !item_stall, "register write left the block busy")

endmodule

bind windowed_softmax_attention_top wsa_checker u_wsa_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .config_valid (config_valid),
  .config_ready (config_ready)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Windowed softmax attention bench
// Fills the q/k/v rows that reads can reach, then runs directed and random
// load/read traffic over several small token counts. Reads are scored against
// an in-bench attention predictor, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
  import wsa_pkg::*;
;

  localparam int MAXT      = 128;
  localparam int HDIM      = 128;
  localparam int DEPTH     = MAXT * HDIM;
  localparam int FILL_ROWS = 8;
  localparam int LIMIT     = 1000000;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    config_valid;
  logic    config_ready;
  logic [7:0] config_data;

  windowed_softmax_attention_top #(.MAX_TOKENS(MAXT), .HEAD_DIM(HDIM)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .config_valid(config_valid), .config_ready(config_ready), .config_data(config_data)
  );

  // 2^16 * 2^(-j/16), rounded
  localparam longint EXP_FRAC [16] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219
  };

  // Shadow of the block: stores, probability cache and token count.
  logic signed [15:0] q_mem [DEPTH];
  logic signed [15:0] k_mem [DEPTH];
  logic signed [15:0] v_mem [DEPTH];
  longint             prob_cache [MAXT];
  int                 cache_token;
  bit                 cache_ok;
  int                 token_count;
  longint             score_scale;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors;
  int      idle_max;
  int      tx_gap;
  int      rx_wait;
  bit      rx_hold;
  int      cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint round_shr(input longint x, input int sh);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (x < 0) ? -m : m;
  endfunction

  // Rounded integer square root, linear search is fine at this size.
  function automatic longint sqrt_rounded(input longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic int live_tokens();
    if (token_count == 0) return 1;
    if (token_count > MAXT) return MAXT;
    return token_count;
  endfunction

  // Score row t against every live key, softmax from the row maximum, cache it.
  task automatic softmax_row(input int t, input int n);
    longint scores [MAXT];
    longint exps [MAXT];
    longint dot, mx, sum, diff, t16, ip;
    mx  = 0;
    sum = 0;
    for (int b = 0; b < n; b++) begin
      dot = 0;
      for (int d = 0; d < HDIM; d++)
        dot += longint'(q_mem[t*HDIM+d]) * longint'(k_mem[b*HDIM+d]);
      scores[b] = round_shr(dot * score_scale, 27);
      if (b == 0 || scores[b] > mx) mx = scores[b];
    end
    for (int b = 0; b < n; b++) begin
      diff = mx - scores[b];
      t16 = (diff * 94548 + (64'sd1 <<< 22)) >>> 23;
      ip = t16 >>> 4;
      exps[b] = (ip >= 17) ? 0 : (EXP_FRAC[t16 & 15] >>> ip);
      sum += exps[b];
    end
    for (int b = 0; b < n; b++)
      prob_cache[b] = (exps[b] * 32768 + sum / 2) / sum;
    cache_token = t;
    cache_ok = 1'b1;
  endtask

  // Advance the shadow by one accepted beat; queue the result a read causes.
  task automatic attend(input item_t it);
    result_t r;
    int n, a;
    longint acc, res;
    if (it.op == OP_LOAD) begin
      a = it.token * HDIM + it.dim;
      q_mem[a] = it.query_value;
      k_mem[a] = it.key_value;
      v_mem[a] = it.value_value;
      cache_ok = 1'b0;
      return;
    end
    n = live_tokens();
    r.out_token = it.token;
    r.out_dim = it.dim;
    r.out_value = '0;
    if (it.token < n) begin
      if (!cache_ok || cache_token != it.token) softmax_row(it.token, n);
      acc = 0;
      for (int b = 0; b < n; b++)
        acc += prob_cache[b] * longint'(v_mem[b*HDIM+it.dim]);
      res = round_shr(acc, 15);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.out_value = res[15:0];
    end
    expected_results.push_back(r);
  endtask

  // Driver: present queued beats, with a drawn gap after each one.
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      tx_gap <= 0;
    end else begin
      busy = item_valid;
      if (item_valid && !item_stall) begin
        attend(item);
        busy = 1'b0;
      end
      if (busy) begin
        item_valid <= 1'b1;
      end else if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        tx_gap <= $urandom_range(0, idle_max);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall for a drawn count after each beat, check against the oldest
  // expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b1;
      rx_wait <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected, token", longint'(result.out_token), -1);
        end else begin
          want = expected_results.pop_front();
          if (result.out_value !== want.out_value)
            report("out_value", result.out_value, want.out_value);
          if (result.out_token !== want.out_token)
            report("out_token", result.out_token, want.out_token);
          if (result.out_dim !== want.out_dim)
            report("out_dim", result.out_dim, want.out_dim);
        end
        rx_wait <= $urandom_range(0, idle_max);
        result_stall <= 1'b1;
      end else begin
        if (rx_wait != 0) rx_wait <= rx_wait - 1;
        result_stall <= (rx_wait > 1) || rx_hold;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_load(input int t, input int d, input logic [15:0] q,
                           input logic [15:0] k, input logic [15:0] v);
    item_t it;
    it.op = OP_LOAD;
    it.token = 7'(t);
    it.dim = 7'(d);
    it.query_value = q;
    it.key_value = k;
    it.value_value = v;
    pending_items.push_back(it);
  endtask

  task automatic push_read(input int t, input int d);
    item_t it;
    it = '0;
    it.op = OP_READ;
    it.token = 7'(t);
    it.dim = 7'(d);
    it.query_value = 16'($urandom);
    it.key_value = 16'($urandom);
    it.value_value = 16'($urandom);
    pending_items.push_back(it);
  endtask

  // Hold until every beat is out and answered, then let a trailing load settle.
  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [7:0] v);
    config_data <= v;
    config_valid <= 1'b1;
    @(posedge clk);
    while (!config_ready) @(posedge clk);
    token_count = int'(v);
    cache_ok = 1'b0;
    config_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One phase of random traffic: mostly load bursts followed by reads of one
  // row, plus stray reads at any token, most of them past the token count.
  task automatic random_phase(input int beats);
    int n, row, left;
    n = live_tokens();
    left = beats;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(0, 3)) begin
          push_load($urandom_range(0, MAXT-1), $urandom_range(0, HDIM-1),
                    16'($urandom), 16'($urandom), 16'($urandom));
          left--;
        end
        row = $urandom_range(0, n-1);
        repeat ($urandom_range(3, 10)) begin
          push_read(row, $urandom_range(0, HDIM-1));
          left--;
        end
      end else begin
        push_read($urandom_range(0, MAXT-1), $urandom_range(0, HDIM-1));
        left--;
      end
    end
  endtask

  initial begin
    logic [7:0] counts [8];
    errors = 0;
    cycles = 0;
    idle_max = 17;
    rx_hold = 1'b0;
    cache_ok = 1'b0;
    cache_token = 0;
    token_count = 128;
    score_scale = sqrt_rounded(64'd4294967296 / HDIM);
    config_valid = 1'b0;
    config_data = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill every row a read can reach at the token counts used below.
    for (int t = 0; t < FILL_ROWS; t++)
      for (int d = 0; d < HDIM; d++)
        push_load(t, d, 16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    // Count zero acts as one token; token one is already out of range.
    write_count(8'd0);
    push_read(0, 3);
    push_read(1, 3);
    drain();

    // Field extremes on a small window, reads at the last head element and past the count.
    write_count(8'd4);
    idle_max = 0;
    push_load(0, 0, 16'sh8000, 16'sh8000, 16'sh7fff);
    push_load(1, 0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_load(2, HDIM-1, 16'sh7fff, 16'sh8000, 16'sh0000);
    push_read(0, 0);
    push_read(0, 1);
    push_read(1, 0);
    push_read(3, HDIM-1);
    push_read(4, 5);
    push_read(MAXT-1, HDIM-1);
    drain();

    // Random phases over several counts; gaps on and off by turns.
    counts = '{8'd3, 8'd8, 8'd1, 8'd6, 8'd2, 8'd5, 8'd7, 8'd4};
    for (int p = 0; p < 8; p++) begin
      idle_max = (p % 2 == 0) ? 17 : 0;
      write_count(counts[p]);
      if (counts[p] == 2) begin
        // Pressure: freeze the receiver while reads keep coming.
        for (int i = 0; i < 30; i++) push_read(i % 2, $urandom_range(0, HDIM-1));
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
        random_phase(20);
      end else begin
        random_phase(30);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
